// ===== sv/ahd_pkg.sv =====
// shared types, constants and helper functions for the ash link handshake detector
`timescale 1ns / 1ps

package ahd_pkg;

	// frame size limit and derived counter widths
	localparam int MAX_FRAME_BYTES = 256;
	localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);

	// leading bytes kept per direction
	localparam int NCP_HEAD_DEPTH  = 3;
	localparam int HOST_HEAD_DEPTH = 5;
	localparam int NCP_IDX_W       = $clog2(NCP_HEAD_DEPTH);
	localparam int HOST_IDX_W      = $clog2(HOST_HEAD_DEPTH);

	// function codes on the input channel
	localparam logic [1:0] FUNC_NCP  = 2'd0;
	localparam logic [1:0] FUNC_HOST = 2'd1;
	localparam logic [1:0] FUNC_TAKE = 2'd2;

	// reserved link bytes
	localparam logic [7:0] BYTE_FLAG   = 8'h7E;
	localparam logic [7:0] BYTE_ESC    = 8'h7D;
	localparam logic [7:0] BYTE_XON    = 8'h11;
	localparam logic [7:0] BYTE_XOFF   = 8'h13;
	localparam logic [7:0] BYTE_SUB    = 8'h18;
	localparam logic [7:0] BYTE_CANCEL = 8'h1A;
	localparam logic [7:0] ESC_XOR     = 8'h20;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// frame contents
	localparam logic [7:0] CTL_RSTACK      = 8'hC1;
	localparam logic [7:0] RSTACK_VERSION  = 8'h02;
	localparam int         CTL_NON_DATA    = 7;
	localparam int         CTL_RETX        = 3;
	localparam logic [7:0] VER_CMD_B0      = 8'h00;
	localparam logic [7:0] VER_CMD_B1      = 8'h42;
	localparam logic [7:0] VER_CMD_B2      = 8'h21;
	localparam logic [7:0] VER_CMD_B3      = 8'hA8;
	localparam logic [7:0] VER_XOR         = 8'h54;

	// kept byte count that closes a frame of a given body length (body + 2 crc bytes)
	localparam logic [CNT_W-1:0] RSTACK_CNT  = CNT_W'(5);
	localparam logic [CNT_W-1:0] VER_CMD_CNT = CNT_W'(7);
	localparam logic [CNT_W-1:0] MIN_CNT     = CNT_W'(3);
	localparam logic [CNT_W-1:0] MAX_CNT     = CNT_W'(MAX_FRAME_BYTES);

	localparam logic [3:0] REJECT_LIMIT_RST = 4'd4;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_SAW_RSTACK = 2'd1,
		MODE_ARMED = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		SCAN_NONE    = 2'd0,
		SCAN_FRAME   = 2'd1,
		SCAN_INVALID = 2'd2
	} scan_t;

	// what a deframer reports for the current beat
	typedef struct packed {
		scan_t                 ev;
		logic [CNT_W-1:0]      len;
		logic                  store;
		logic [HOST_IDX_W-1:0] wr_idx;
		logic [7:0]            wr_data;
	} dfr_out_t;

	// one result beat
	typedef struct packed {
		logic       data_frame_ready;
		mode_t      mode;
		logic       ack_valid;
		logic [2:0] ack_number;
		logic [7:0] version;
	} ahd_result_t;

	function automatic logic is_reserved(input logic [7:0] v);
		return v == BYTE_FLAG || v == BYTE_ESC || v == BYTE_XON || v == BYTE_XOFF ||
			v == BYTE_SUB || v == BYTE_CANCEL;
	endfunction

	function automatic logic reset_code_known(input logic [7:0] c);
		return c == 8'h00 || c == 8'h01 || c == 8'h02 || c == 8'h03 || c == 8'h06 ||
			c == 8'h09 || c == 8'h0B || c == 8'h51 || c == 8'h80 || c == 8'h81;
	endfunction

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== sv/ash_link_handshake_detector.sv =====
// top level of the ash link handshake detector: input stage, deframers, result register
`timescale 1ns / 1ps

// usage
//   input channel (in_valid/in_ready): one beat per link byte or request.
//     func 0 carries a byte seen from the coprocessor, func 1 a byte from the host,
//     func 2 takes the owed acknowledgement; line_byte is ignored for func 2 and 3.
//   output channel (out_valid/out_ready): exactly one result beat per input beat,
//     in order, with the mode and version as they stand after that beat.
//   config: cfg_we writes cfg_wdata into reject_limit in the same cycle, no handshake;
//     write it only while no beat is in flight.
// pipeline and throughput
//   an accepted beat lands in the input stage and is processed into the result
//   register, which drives the output; one beat per cycle while out_ready is high.
//   the byte-wide crc update and the frame checks sit between the input stage
//   and the result register.
// stalls and reset
//   while out_ready is low the result holds and the input stage keeps one beat;
//   in_ready drops only when both are full.
//   arst_n clears deframers, mode (idle), sequence, owed ack, reject count,
//   version and sets reject_limit to 4; no beats are held after reset.

module ash_link_handshake_detector (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] func,
	input  logic [7:0] line_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       data_frame_ready,
	output logic [1:0] detect_mode,
	output logic       ack_valid,
	output logic [2:0] ack_number,
	output logic [7:0] protocol_version,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata
);
	import ahd_pkg::*;

	// input stage
	logic       valid_s1;
	logic [1:0] func_s1;
	logic [7:0] byte_s1;

	// result register
	logic        out_valid_q;
	ahd_result_t result_q;

	logic        advance;
	dfr_out_t    ncp_dfr, host_dfr;
	ahd_result_t result_d;

	// process the staged beat when the result register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload of the input stage needs no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1 <= func;
			byte_s1 <= line_byte;
		end
	end

	// coprocessor to host direction
	ahd_deframer u_ncp_dfr (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance && func_s1 == FUNC_NCP),
		.line_byte (byte_s1),
		.res       (ncp_dfr)
	);

	// host to coprocessor direction
	ahd_deframer u_host_dfr (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance && func_s1 == FUNC_HOST),
		.line_byte (byte_s1),
		.res       (host_dfr)
	);

	// mode tracking, sequence and ack bookkeeping
	ahd_link_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.func      (func_s1),
		.ncp_dfr   (ncp_dfr),
		.host_dfr  (host_dfr),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.res       (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign data_frame_ready = result_q.data_frame_ready;
	assign detect_mode      = result_q.mode;
	assign ack_valid        = result_q.ack_valid;
	assign ack_number       = result_q.ack_number;
	assign protocol_version = result_q.version;

	// back-pressure only when both the input stage and the result register are full
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("in_ready low without a full pipeline");

	// an accepted data frame is only reported while armed
	a_frame_needs_armed: assert property (@(posedge clk) disable iff (!arst_n)
		advance && result_d.data_frame_ready |=> detect_mode == MODE_ARMED)
		else $error("data frame reported outside armed mode");

	// no ack number without an owed ack
	a_ack_number_zero: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !result_d.ack_valid |=> ack_number == 3'd0)
		else $error("ack number set without a valid ack");

	// only a take request can return an ack
	a_ack_only_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		advance && result_d.ack_valid |-> func_s1 == FUNC_TAKE)
		else $error("ack returned for a link byte");

	// a staged beat is never dropped while stalled
	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(func_s1))
		else $error("input stage lost a stalled beat");

endmodule

// ===== sv/ahd_deframer.sv =====
// one-direction ash deframer: flag, escape, cancel, substitute, crc check
`timescale 1ns / 1ps

module ahd_deframer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic [7:0]      line_byte,
	output ahd_pkg::dfr_out_t res
);
	import ahd_pkg::*;

	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [15:0]      crc_q, crc_d;
	logic             esc_q, esc_d;
	logic             poison_q, poison_d;
	logic             discard_q, discard_d;
	logic [7:0]       v;
	logic             keep;

	always_comb begin
		cnt_d     = cnt_q;
		crc_d     = crc_q;
		esc_d     = esc_q;
		poison_d  = poison_q;
		discard_d = discard_q;
		res       = '0;
		res.ev    = SCAN_NONE;
		res.len   = cnt_q;
		res.wr_idx = cnt_q[HOST_IDX_W-1:0];
		v         = line_byte;
		keep      = 1'b0;
		if (en) begin
			if (line_byte == BYTE_FLAG) begin
				cnt_d     = '0;
				crc_d     = CRC_INIT;
				esc_d     = 1'b0;
				poison_d  = 1'b0;
				discard_d = 1'b0;
				if (discard_q || cnt_q == '0) begin
					res.ev = SCAN_NONE;
				end else if (poison_q || esc_q || cnt_q < MIN_CNT || crc_q != '0) begin
					res.ev = SCAN_INVALID;
				end else begin
					res.ev = SCAN_FRAME;
				end
			end else if (!discard_q) begin
				unique case (line_byte) inside
					BYTE_CANCEL: begin
						cnt_d    = '0;
						crc_d    = CRC_INIT;
						esc_d    = 1'b0;
						poison_d = 1'b0;
					end
					BYTE_SUB: discard_d = 1'b1;
					BYTE_XON, BYTE_XOFF: ;
					BYTE_ESC: esc_d = 1'b1;
					default: begin
						keep = 1'b1;
						if (esc_q) begin
							esc_d = 1'b0;
							v     = line_byte ^ ESC_XOR;
							if (!is_reserved(v)) begin
								poison_d = 1'b1;
								keep     = 1'b0;
							end
						end
						if (keep && cnt_q >= MAX_CNT) begin
							poison_d = 1'b1;
							keep     = 1'b0;
						end
						if (keep) begin
							cnt_d       = cnt_q + CNT_W'(1);
							crc_d       = crc_byte(crc_q, v);
							res.store   = cnt_q < CNT_W'(HOST_HEAD_DEPTH);
							res.wr_data = v;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			crc_q     <= CRC_INIT;
			esc_q     <= 1'b0;
			poison_q  <= 1'b0;
			discard_q <= 1'b0;
		end else begin
			cnt_q     <= cnt_d;
			crc_q     <= crc_d;
			esc_q     <= esc_d;
			poison_q  <= poison_d;
			discard_q <= discard_d;
		end
	end

endmodule

// ===== sv/ahd_link_ctrl.sv =====
// link state tracking: mode, frame sequence, owed ack, rejects, version
`timescale 1ns / 1ps

module ahd_link_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic [1:0]           func,
	input  ahd_pkg::dfr_out_t    ncp_dfr,
	input  ahd_pkg::dfr_out_t    host_dfr,
	input  logic                 cfg_we,
	input  logic [3:0]           cfg_wdata,
	output ahd_pkg::ahd_result_t res
);
	import ahd_pkg::*;

	logic [7:0] ncp_head_q  [NCP_HEAD_DEPTH];
	logic [7:0] host_head_q [HOST_HEAD_DEPTH];

	mode_t      mode_q, mode_d;
	logic [2:0] exp_q, exp_d;
	logic       owed_v_q, owed_v_d;
	logic [2:0] owed_n_q, owed_n_d;
	logic [3:0] rej_q, rej_d;
	logic [7:0] ver_q, ver_d;
	logic [3:0] limit_q;

	logic [3:0] rej_inc;
	logic       reject;
	logic [7:0] ctl;
	logic [2:0] exp_inc;

	// leading bytes of the frame in progress
	always_ff @(posedge clk) begin
		if (ncp_dfr.store && ncp_dfr.wr_idx < HOST_IDX_W'(NCP_HEAD_DEPTH)) begin
			ncp_head_q[ncp_dfr.wr_idx[NCP_IDX_W-1:0]] <= ncp_dfr.wr_data;
		end
		if (host_dfr.store) begin
			host_head_q[host_dfr.wr_idx] <= host_dfr.wr_data;
		end
	end

	always_comb begin
		mode_d   = mode_q;
		exp_d    = exp_q;
		owed_v_d = owed_v_q;
		owed_n_d = owed_n_q;
		rej_d    = rej_q;
		ver_d    = ver_q;
		reject   = 1'b0;
		res      = '0;
		rej_inc  = rej_q + 4'd1;
		exp_inc  = exp_q + 3'd1;
		ctl      = ncp_head_q[0];
		if (advance) begin
			case (func)
				FUNC_NCP: begin
					if (ncp_dfr.ev == SCAN_FRAME) begin
						if (ctl == CTL_RSTACK) begin
							if (ncp_dfr.len == RSTACK_CNT && ncp_head_q[1] == RSTACK_VERSION &&
								reset_code_known(ncp_head_q[2])) begin
								mode_d   = MODE_SAW_RSTACK;
								exp_d    = '0;
								owed_v_d = 1'b0;
								rej_d    = '0;
							end
						end else if (mode_q == MODE_ARMED && !ctl[CTL_NON_DATA]) begin
							if (ctl[6:4] != exp_q) begin
								if (ctl[CTL_RETX]) begin
									rej_d = '0;
								end else begin
									reject = 1'b1;
								end
							end else begin
								exp_d    = exp_inc;
								owed_v_d = 1'b1;
								owed_n_d = exp_inc;
								rej_d    = '0;
								res.data_frame_ready = 1'b1;
							end
						end
					end else if (ncp_dfr.ev == SCAN_INVALID) begin
						reject = 1'b1;
					end
				end
				FUNC_HOST: begin
					if (host_dfr.ev == SCAN_FRAME && mode_q == MODE_SAW_RSTACK &&
						host_dfr.len == VER_CMD_CNT && host_head_q[0] == VER_CMD_B0 &&
						host_head_q[1] == VER_CMD_B1 && host_head_q[2] == VER_CMD_B2 &&
						host_head_q[3] == VER_CMD_B3) begin
						ver_d    = host_head_q[4] ^ VER_XOR;
						mode_d   = MODE_ARMED;
						exp_d    = '0;
						owed_v_d = 1'b0;
						rej_d    = '0;
					end
				end
				FUNC_TAKE: begin
					if (owed_v_q) begin
						res.ack_valid  = 1'b1;
						res.ack_number = owed_n_q;
						owed_v_d       = 1'b0;
					end
				end
				default: ;
			endcase
			// rejects only count while armed
			if (reject && mode_q == MODE_ARMED) begin
				if (rej_inc >= limit_q) begin
					mode_d = MODE_IDLE;
					rej_d  = '0;
				end else begin
					rej_d = rej_inc;
				end
			end
		end
		res.mode    = mode_d;
		res.version = ver_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			exp_q    <= '0;
			owed_v_q <= 1'b0;
			owed_n_q <= '0;
			rej_q    <= '0;
			ver_q    <= '0;
			limit_q  <= REJECT_LIMIT_RST;
		end else begin
			mode_q   <= mode_d;
			exp_q    <= exp_d;
			owed_v_q <= owed_v_d;
			owed_n_q <= owed_n_d;
			rej_q    <= rej_d;
			ver_q    <= ver_d;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
		end
	end

endmodule
